// ===== hdl/adbh_pkg.sv =====
// Shared types, constants and AES helper functions for the double-block AES-256 hash.
`default_nettype none
package adbh_pkg;

    localparam logic FUNC_ABSORB   = 1'b0;
    localparam logic FUNC_FINALIZE = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [63:0] digest_word;
        logic        last_word;
    } out_item_t;

    typedef struct packed {
        logic         fin;
        logic [127:0] block;
    } job_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RCON [7] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40};

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // byte i of a 128-bit block sits at bits 127-8i..120-8i
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                               input logic last);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, all;
        logic [127:0] o;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[i + 4 * c] = SBOX[s[127 - 8 * (i + 4 * ((c + i) & 3)) -: 8]];
            end
        end
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[4 * c];
                a1 = t[4 * c + 1];
                a2 = t[4 * c + 2];
                a3 = t[4 * c + 3];
                all = a0 ^ a1 ^ a2 ^ a3;
                t[4 * c]     = a0 ^ all ^ xtime(a0 ^ a1);
                t[4 * c + 1] = a1 ^ all ^ xtime(a1 ^ a2);
                t[4 * c + 2] = a2 ^ all ^ xtime(a2 ^ a3);
                t[4 * c + 3] = a3 ^ all ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) begin
            o[127 - 8 * i -: 8] = t[i];
        end
        return o ^ rk;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/adbh_front.sv =====
// Front end: gathers message bytes into blocks and issues compress jobs.
`default_nettype none
module adbh_front
    import adbh_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire in_item_t s_item,
    input  wire logic     s_valid,
    output logic          s_ready,
    output job_t          job,
    output logic          job_valid,
    input  wire logic     job_ready
);
    logic [127:0] buf_reg, buf_next;
    logic [3:0]   fill_reg, fill_next;
    job_t         job_reg, job_next;
    logic         jv_reg, jv_next;

    assign s_ready   = !jv_reg || job_ready;
    assign job       = job_reg;
    assign job_valid = jv_reg;

    always_comb begin
        buf_next  = buf_reg;
        fill_next = fill_reg;
        job_next  = job_reg;
        jv_next   = jv_reg && !job_ready;
        if (s_valid && s_ready) begin
            if (s_item.func == FUNC_ABSORB) begin
                buf_next[127 - 8 * fill_reg -: 8] = s_item.data_byte;
                fill_next = fill_reg + 4'd1;
                if (fill_reg == 4'd15) begin
                    job_next.fin   = 1'b0;
                    job_next.block = buf_next;
                    jv_next        = 1'b1;
                end
            end else begin
                for (int i = 0; i < 16; i++) begin
                    if (4'(i) >= fill_reg) begin
                        buf_next[127 - 8 * i -: 8] = 8'h00;
                    end
                end
                job_next.fin   = 1'b1;
                job_next.block = buf_next;
                jv_next        = 1'b1;
                fill_next      = 4'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg <= buf_next;
        job_reg <= job_next;
        if (!aresetn) begin
            fill_reg <= 4'd0;
            jv_reg   <= 1'b0;
        end else begin
            fill_reg <= fill_next;
            jv_reg   <= jv_next;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/adbh_back.sv =====
// Back end: iterative AES-256 core running compressions and the digest pass.
`default_nettype none
module adbh_back
    import adbh_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire job_t  job,
    input  wire logic  job_valid,
    output logic       job_ready,
    output out_item_t  m_item,
    output logic       m_valid,
    input  wire logic  m_ready
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ENC  = 3'd1;
    localparam logic [2:0] ST_OUT  = 3'd2;

    logic [2:0]   st_reg, st_next;
    logic [255:0] tb_reg, tb_next;
    logic [255:0] key_reg, key_next;
    logic [127:0] sa_reg, sa_next, sb_reg, sb_next;
    logic [3:0]   rnd_reg, rnd_next;
    logic [2:0]   rci_reg, rci_next;
    logic         fin_reg, fin_next, dig_reg, dig_next;
    logic [1:0]   wi_reg, wi_next;
    logic         mv_reg, mv_next;
    out_item_t    mo_reg, mo_next;

    logic [127:0] rk, sa_r, sb_r;
    logic [31:0]  w0, w1, w2, w3, w4, w5, w6, w7, tmp;
    logic [255:0] key_adv, init_key;

    assign job_ready = (st_reg == ST_IDLE) && !mv_reg;
    assign m_item    = mo_reg;
    assign m_valid   = mv_reg;

    // key_reg holds round keys 2r..2r+1 pair; odd rounds use lower half
    assign rk = rnd_reg[0] ? key_reg[127:0] : key_reg[255:128];
    assign sa_r = aes_round(sa_reg, rk, rnd_reg == 4'd14);
    assign sb_r = aes_round(sb_reg, rk, rnd_reg == 4'd14);

    always_comb begin
        tmp = {key_reg[23:0], key_reg[31:24]};
        tmp = sub_word(tmp) ^ {RCON[rci_reg], 24'h0};
        w0 = key_reg[255:224] ^ tmp;
        w1 = key_reg[223:192] ^ w0;
        w2 = key_reg[191:160] ^ w1;
        w3 = key_reg[159:128] ^ w2;
        w4 = key_reg[127:96] ^ sub_word(w3);
        w5 = key_reg[95:64] ^ w4;
        w6 = key_reg[63:32] ^ w5;
        w7 = key_reg[31:0] ^ w6;
        key_adv = {w0, w1, w2, w3, w4, w5, w6, w7};
    end

    always_comb begin
        st_next  = st_reg;
        tb_next  = tb_reg;
        key_next = key_reg;
        sa_next  = sa_reg;
        sb_next  = sb_reg;
        rnd_next = rnd_reg;
        rci_next = rci_reg;
        fin_next = fin_reg;
        dig_next = dig_reg;
        wi_next  = wi_reg;
        mv_next  = mv_reg && !m_ready;
        mo_next  = mo_reg;
        init_key = {job.block, tb_reg[127:0]};
        case (st_reg)
            ST_IDLE: begin
                if (job_valid && job_ready) begin
                    fin_next = job.fin;
                    dig_next = 1'b0;
                    key_next = init_key;
                    sa_next  = tb_reg[255:128] ^ init_key[255:128];
                    sb_next  = {tb_reg[255:136], tb_reg[135:128] ^ 8'h01} ^ init_key[255:128];
                    rnd_next = 4'd1;
                    rci_next = 3'd0;
                    st_next  = ST_ENC;
                end
            end
            ST_ENC: begin
                sa_next  = sa_r;
                sb_next  = sb_r;
                rnd_next = rnd_reg + 4'd1;
                if (rnd_reg[0]) begin
                    key_next = key_adv;
                    if (rci_reg != 3'd6) begin
                        rci_next = rci_reg + 3'd1;
                    end
                end
                if (rnd_reg == 4'd14) begin
                    if (dig_reg) begin
                        tb_next = {sa_r, sb_r};
                        wi_next = 2'd0;
                        st_next = ST_OUT;
                    end else if (fin_reg) begin
                        dig_next = 1'b1;
                        key_next = {sa_r, sb_r};
                        sa_next  = {120'h0, 8'h02} ^ sa_r;
                        sb_next  = {120'h0, 8'h03} ^ sa_r;
                        rnd_next = 4'd1;
                        rci_next = 3'd0;
                    end else begin
                        tb_next = {sa_r, sb_r};
                        st_next = ST_IDLE;
                    end
                end
            end
            ST_OUT: begin
                if (!mv_reg || m_ready) begin
                    mo_next.digest_word = tb_reg[255 - 64 * wi_reg -: 64];
                    mo_next.last_word   = (wi_reg == 2'd3);
                    mv_next = 1'b1;
                    wi_next = wi_reg + 2'd1;
                    if (wi_reg == 2'd3) begin
                        tb_next = '0;
                        st_next = ST_IDLE;
                    end
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        sa_reg  <= sa_next;
        sb_reg  <= sb_next;
        rnd_reg <= rnd_next;
        rci_reg <= rci_next;
        fin_reg <= fin_next;
        dig_reg <= dig_next;
        wi_reg  <= wi_next;
        mo_reg  <= mo_next;
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            tb_reg <= '0;
            mv_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            tb_reg <= tb_next;
            mv_reg <= mv_next;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/aes256_double_block_hash.sv =====
// A finalize, once accepted, passes the handoff, a 14-round compression and a 14-round digest pass;
// then the result items follow, one result item per cycle while m_ready is high.
// AES round unit: one round per cycle, on-the-fly key schedule, two blocks in parallel.
// Throughput: one byte per cycle sustained, each compression hides behind the next 16 bytes;
// a finalize holds the round unit through its digest pass and result output, stalling input.
// Reset: aresetn, synchronous active low, clears chaining value, fill count and queue.
`default_nettype none
module aes256_double_block_hash
    import adbh_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire in_item_t s_item,
    input  wire logic     s_valid,
    output logic          s_ready,
    output out_item_t     m_item,
    output logic          m_valid,
    input  wire logic     m_ready
);
    job_t job;
    logic job_valid, job_ready;

    adbh_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_item(s_item), .s_valid(s_valid),
        .s_ready(s_ready), .job(job), .job_valid(job_valid), .job_ready(job_ready)
    );

    adbh_back u_back (
        .aclk(aclk), .aresetn(aresetn), .job(job), .job_valid(job_valid),
        .job_ready(job_ready), .m_item(m_item), .m_valid(m_valid), .m_ready(m_ready)
    );

`ifndef SYNTH
    a_job_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        job_valid && !job_ready |=> job_valid && $stable(job))
        else $error("job changed while stalled");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");
`endif
endmodule
`default_nettype wire

// ===== sim/aes256_double_block_hash_tb.sv =====
// Testbench for aes256_double_block_hash: random byte streams and finalizes checked against a predictor.
`default_nettype none
module aes256_double_block_hash_tb
    import adbh_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    class digest_board;
        logic [127:0] chain_t;
        logic [127:0] chain_b;
        logic [7:0]   blk [16];
        int           fill;
        out_item_t    pending [$];
        int           mismatches;

        function new();
            chain_t = '0;
            chain_b = '0;
            fill = 0;
            mismatches = 0;
            foreach (blk[i]) blk[i] = 8'h00;
        endfunction

        function automatic logic [7:0] sb(input logic [7:0] v);
            logic [7:0] tbl [256];
            tbl = SBOX;
            return tbl[v];
        endfunction

        function automatic logic [7:0] xt(input logic [7:0] v);
            return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
        endfunction

        // key bytes 0..31 at bits 255-8i; round keys as 15 x 128 bits
        function automatic void key_sched(input logic [255:0] key,
                                          output logic [127:0] rk [15]);
            logic [31:0] w [60];
            logic [31:0] tmp;
            logic [7:0]  rc [7];
            rc = RCON;
            for (int i = 0; i < 8; i++) w[i] = key[255 - 32 * i -: 32];
            for (int i = 8; i < 60; i++) begin
                tmp = w[i - 1];
                if ((i % 8) == 0) begin
                    tmp = {sb(tmp[23:16]) ^ rc[i / 8 - 1], sb(tmp[15:8]), sb(tmp[7:0]),
                           sb(tmp[31:24])};
                end else if ((i % 8) == 4) begin
                    tmp = {sb(tmp[31:24]), sb(tmp[23:16]), sb(tmp[15:8]), sb(tmp[7:0])};
                end
                w[i] = w[i - 8] ^ tmp;
            end
            for (int r = 0; r < 15; r++)
                rk[r] = {w[4 * r], w[4 * r + 1], w[4 * r + 2], w[4 * r + 3]};
        endfunction

        function automatic logic [127:0] cipher(input logic [127:0] rk [15], input logic [127:0] pt);
            logic [7:0] s [16];
            logic [7:0] t [16];
            logic [7:0] a0, a1, a2, a3, al;
            logic [127:0] o;
            for (int i = 0; i < 16; i++) s[i] = pt[127 - 8 * i -: 8] ^ rk[0][127 - 8 * i -: 8];
            for (int r = 1; r <= 14; r++) begin
                for (int c = 0; c < 4; c++)
                    for (int i = 0; i < 4; i++) t[i + 4 * c] = sb(s[i + 4 * ((c + i) & 3)]);
                if (r < 14) begin
                    for (int c = 0; c < 4; c++) begin
                        a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
                        al = a0 ^ a1 ^ a2 ^ a3;
                        t[4 * c]     = a0 ^ al ^ xt(a0 ^ a1);
                        t[4 * c + 1] = a1 ^ al ^ xt(a1 ^ a2);
                        t[4 * c + 2] = a2 ^ al ^ xt(a2 ^ a3);
                        t[4 * c + 3] = a3 ^ al ^ xt(a3 ^ a0);
                    end
                end
                for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[r][127 - 8 * i -: 8];
            end
            for (int i = 0; i < 16; i++) o[127 - 8 * i -: 8] = s[i];
            return o;
        endfunction

        function automatic void mix_block();
            logic [127:0] m;
            logic [127:0] rk [15];
            logic [127:0] nt;
            for (int i = 0; i < 16; i++) m[127 - 8 * i -: 8] = blk[i];
            key_sched({m, chain_b}, rk);
            nt = cipher(rk, chain_t);
            chain_b = cipher(rk, chain_t ^ 128'h1);
            chain_t = nt;
        endfunction

        function automatic void note_input(input in_item_t it);
            logic [127:0] rk [15];
            logic [255:0] dg;
            out_item_t    e;
            if (it.func == FUNC_ABSORB) begin
                blk[fill] = it.data_byte;
                fill = (fill + 1) % 16;
                if (fill == 0) mix_block();
                return;
            end
            for (int i = fill; i < 16; i++) blk[i] = 8'h00;
            mix_block();
            key_sched({chain_t, chain_b}, rk);
            dg = {cipher(rk, 128'h2), cipher(rk, 128'h3)};
            for (int k = 0; k < 4; k++) begin
                e.digest_word = dg[255 - 64 * k -: 64];
                e.last_word = (k == 3);
                pending.push_back(e);
            end
            chain_t = '0;
            chain_b = '0;
            fill = 0;
        endfunction

        function automatic void check_result(input out_item_t got);
            out_item_t e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected item %h", got);
                return;
            end
            e = pending.pop_front();
            if (got.digest_word !== e.digest_word || got.last_word !== e.last_word) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp word %h last %b, got word %h last %b",
                             e.digest_word, e.last_word, got.digest_word, got.last_word);
            end
        endfunction
    endclass

    logic      aclk;
    logic      aresetn;
    in_item_t  s_item;
    logic      s_valid;
    logic      s_ready;
    out_item_t m_item;
    logic      m_valid;
    logic      m_ready;
    bit        calm;
    digest_board board;

    aes256_double_block_hash u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_item(s_item), .s_valid(s_valid), .s_ready(s_ready),
        .m_item(m_item), .m_valid(m_valid), .m_ready(m_ready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

    function automatic bit idle_now();
        return !calm && ($urandom_range(99) < 17);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) board.check_result(m_item);
            m_ready <= !idle_now();
        end
    end

    task automatic send(input logic fn, input logic [7:0] d);
        while (idle_now()) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_item <= '{func: fn, data_byte: d};
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        board.note_input('{func: fn, data_byte: d});
    endtask

    task automatic send_msg(input int len, input int mode);
        for (int i = 0; i < len; i++) begin
            case (mode)
                0: send(FUNC_ABSORB, 8'h00);
                1: send(FUNC_ABSORB, 8'hff);
                default: send(FUNC_ABSORB, 8'($urandom));
            endcase
        end
        send(FUNC_FINALIZE, 8'($urandom));
    endtask

    initial begin
        int sent;
        int len;
        board = new();
        calm = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item = '0;
        m_ready = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // directed: empty message, single bytes, full block, two-byte message, empty message
        send_msg(0, 0);
        send_msg(1, 1);
        send_msg(1, 0);
        send_msg(16, 1);
        send(FUNC_ABSORB, 8'haa);
        send(FUNC_ABSORB, 8'h55);
        send(FUNC_FINALIZE, 8'hff);
        send(FUNC_FINALIZE, 8'h00);
        sent = 0;
        while (sent < 100) begin
            calm = (sent > 30 && sent < 60);
            len = ($urandom_range(3) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 17);
            send_msg(len, 2);
            sent += len + 1;
        end
        s_valid <= 1'b0;
        calm = 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire
